### rtl/timestamp_ordered_request_queue_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the request queue checker
// Shorthand for clocked implication properties with reset disable.
// ----------------------------------------------------------------------------
`ifndef TIMESTAMP_ORDERED_REQUEST_QUEUE_MACROS_SVH
`define TIMESTAMP_ORDERED_REQUEST_QUEUE_MACROS_SVH

// same-cycle implication
`define TSOQ_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define TSOQ_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/tsoq_pkg.sv
// ----------------------------------------------------------------------------
// Request queue package
// Entry layout, per-cycle cell control and result codes.
// ----------------------------------------------------------------------------
package tsoq_pkg;

    localparam int STAMP_W = 15;
    localparam int PROC_W  = 7;
    localparam int ID_W    = 8;

    localparam logic [ID_W-1:0] NO_ID = 8'hFF;

    localparam logic ACT_PUSH = 1'b0;
    localparam logic ACT_POP  = 1'b1;

    typedef struct packed {
        logic [STAMP_W-1:0] stamp;
        logic [PROC_W-1:0]  proc;
    } entry_t;

    // broadcast to every cell on a transfer
    typedef struct packed {
        logic push;
        logic pop;
    } cell_ctrl_t;

endpackage

### rtl/timestamp_ordered_request_queue.sv
// ----------------------------------------------------------------------------
// Timestamp ordered request queue
// Sorted queue of (stamp, id) requests built as a row of shifting cells.
// ----------------------------------------------------------------------------
//  channel | handshake            | payload
//  --------+----------------------+---------------------------------------
//  in      | in_valid / in_ready  | action, proc_id, stamp
//  out     | out_valid / out_ready| popped_id, head_id, empty_res, overflow
//
// One item per cycle while in_ready is high: all cells compare with the new key in
// parallel, the row shifts in the transfer cycle, the result shows in the next.
// A new transfer is taken whenever the result register is empty or draining.
// Reset clears the fill count and the result valid; cell contents are left as is.
// head_id/empty_res follow the cell row, which only moves on an input transfer.
// ----------------------------------------------------------------------------
module timestamp_ordered_request_queue #(
    parameter int CAPACITY = 16
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic                         action,
    input  logic [tsoq_pkg::PROC_W-1:0]  proc_id,
    input  logic [tsoq_pkg::STAMP_W-1:0] stamp,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic signed [tsoq_pkg::ID_W-1:0] popped_id,
    output logic signed [tsoq_pkg::ID_W-1:0] head_id,
    output logic                         empty_res,
    output logic                         overflow
);
    import tsoq_pkg::*;

    localparam int CNT_W = $clog2(CAPACITY + 1);

    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             out_valid_reg;
    logic             out_valid_next;
    logic [ID_W-1:0]  popped_reg;
    logic [ID_W-1:0]  popped_next;
    logic             overflow_reg;
    logic             overflow_next;

    logic        xfer;
    logic        full;
    logic        empty;
    cell_ctrl_t  ctrl;
    entry_t      req_key;
    entry_t      cell_entry [CAPACITY];
    logic        cell_go    [CAPACITY];

    assign in_ready  = !out_valid_reg || out_ready;
    assign xfer      = in_valid && in_ready;
    assign full      = (count_reg == CNT_W'(CAPACITY));
    assign empty     = (count_reg == '0);
    assign req_key   = '{stamp: stamp, proc: proc_id};

    assign ctrl.push = xfer && (action == ACT_PUSH) && !full;
    assign ctrl.pop  = xfer && (action == ACT_POP) && !empty;

    for (genvar k = 0; k < CAPACITY; k++)
    begin : g_cell
        entry_t left_e;
        entry_t right_e;
        logic   left_g;

        if (k == 0)
        begin : g_first
            assign left_e = req_key;
            assign left_g = 1'b0;
        end
        else
        begin : g_mid
            assign left_e = cell_entry[k-1];
            assign left_g = cell_go[k-1];
        end

        if (k == CAPACITY - 1)
        begin : g_last
            assign right_e = cell_entry[k];
        end
        else
        begin : g_inner
            assign right_e = cell_entry[k+1];
        end

        tsoq_cell u_cell (
            .clk         (clk),
            .ctrl        (ctrl),
            .req_key     (req_key),
            .valid       (count_reg > CNT_W'(k)),
            .left_entry  (left_e),
            .left_go     (left_g),
            .right_entry (right_e),
            .entry       (cell_entry[k]),
            .go          (cell_go[k])
        );
    end

    always_comb
    begin
        count_next     = count_reg;
        out_valid_next = out_valid_reg;
        popped_next    = popped_reg;
        overflow_next  = overflow_reg;
        if (ctrl.push)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (ctrl.pop)
        begin
            count_next = count_reg - 1'b1;
        end
        if (xfer)
        begin
            out_valid_next = 1'b1;
            popped_next    = ctrl.pop ? {1'b0, cell_entry[0].proc} : NO_ID;
            overflow_next  = (action == ACT_PUSH) && full;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        popped_reg   <= popped_next;
        overflow_reg <= overflow_next;
    end

    assign out_valid = out_valid_reg;
    assign popped_id = popped_reg;
    assign overflow  = overflow_reg;
    assign empty_res = empty;
    assign head_id   = empty ? NO_ID : {1'b0, cell_entry[0].proc};

endmodule

### rtl/tsoq_cell.sv
// ----------------------------------------------------------------------------
// Request queue cell
// Holds one entry; on push shifts right past the insert point, on pop left.
// ----------------------------------------------------------------------------
module tsoq_cell (
    input  logic                clk,
    input  tsoq_pkg::cell_ctrl_t ctrl,
    input  tsoq_pkg::entry_t    req_key,
    input  logic                valid,
    input  tsoq_pkg::entry_t    left_entry,
    input  logic                left_go,
    input  tsoq_pkg::entry_t    right_entry,
    output tsoq_pkg::entry_t    entry,
    output logic                go
);
    import tsoq_pkg::*;

    entry_t entry_reg;
    entry_t entry_next;
    logic   ahead;

    // new entry sorts ahead of this one; equal keys stay behind
    assign ahead = (req_key.stamp < entry_reg.stamp) ||
                   ((req_key.stamp == entry_reg.stamp) &&
                    (req_key.proc < entry_reg.proc));

    // empty cells count as "after the new entry", keeping go monotonic
    assign go = !valid || ahead;

    always_comb
    begin
        entry_next = entry_reg;
        if (ctrl.pop)
        begin
            entry_next = right_entry;
        end
        else if (ctrl.push)
        begin
            if (left_go)
            begin
                entry_next = left_entry;
            end
            else if (go)
            begin
                entry_next = req_key;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;

endmodule

### rtl/tsoq_checker.sv
// ----------------------------------------------------------------------------
// Request queue port checker
// Watches the top-level ports for handshake and result consistency.
// ----------------------------------------------------------------------------
`include "timestamp_ordered_request_queue_macros.svh"

module tsoq_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic       out_valid,
    input logic       out_ready,
    input logic [7:0] popped_id,
    input logic [7:0] head_id,
    input logic       empty_res,
    input logic       overflow
);

    `TSOQ_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(popped_id) && $stable(head_id), "result changed while stalled")

    `TSOQ_ASSERT_NOW(a_ready_when_free, !out_valid, in_ready, "input stalled with no pending result")

    `TSOQ_ASSERT_NEXT(a_result_follows, in_valid && in_ready, out_valid, "no result after an input transfer")

    `TSOQ_ASSERT_NOW(a_empty_head, out_valid, empty_res == (head_id == 8'hFF), "head id disagrees with empty flag")

    `TSOQ_ASSERT_NOW(a_overflow_full, out_valid && overflow, !empty_res && (popped_id == 8'hFF), "overflow on a non-full or popping transfer")

endmodule

bind timestamp_ordered_request_queue tsoq_checker u_tsoq_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .popped_id (popped_id),
    .head_id   (head_id),
    .empty_res (empty_res),
    .overflow  (overflow)
);

### tb/sv/timestamp_ordered_request_queue_checker.sv
// ----------------------------------------------------------------------------
// Request queue checker
// Watches both channels, keeps its own sorted copy of the queue and compares
// every result transfer against the oldest predicted outcome.
// ----------------------------------------------------------------------------
module timestamp_ordered_request_queue_checker #(
    parameter int CAPACITY = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    input  logic                                in_ready,
    input  logic                                action,
    input  logic [tsoq_pkg::PROC_W-1:0]         proc_id,
    input  logic [tsoq_pkg::STAMP_W-1:0]        stamp,
    input  logic                                out_valid,
    input  logic                                out_ready,
    input  logic signed [tsoq_pkg::ID_W-1:0]    popped_id,
    input  logic signed [tsoq_pkg::ID_W-1:0]    head_id,
    input  logic                                empty_res,
    input  logic                                overflow,
    output int                                  outstanding,
    output int                                  mismatches
);
    import tsoq_pkg::*;

    typedef struct packed {
        logic [ID_W-1:0] popped;
        logic [ID_W-1:0] head;
        logic            is_empty;
        logic            dropped;
    } queue_outcome_t;

    logic [STAMP_W-1:0] slot_stamp [CAPACITY];
    logic [PROC_W-1:0]  slot_proc  [CAPACITY];
    int                 fill = 0;
    queue_outcome_t     pending_outcomes [$];
    queue_outcome_t     want;
    int                 bad_fields = 0;

    // Applies one request to the shadow queue and returns what the block must report.
    function automatic queue_outcome_t apply_request(input logic act,
                                                     input logic [PROC_W-1:0] pid,
                                                     input logic [STAMP_W-1:0] st);
        queue_outcome_t res;
        int pos;
        int k;
        res.popped  = NO_ID;
        res.dropped = 1'b0;
        if (act == ACT_PUSH)
        begin
            if (fill >= CAPACITY)
            begin
                res.dropped = 1'b1;
            end
            else
            begin
                pos = 0;
                // an identical key lands behind the ones already stored
                while (pos < fill && (st > slot_stamp[pos] ||
                       (st == slot_stamp[pos] && pid >= slot_proc[pos])))
                    pos++;
                for (k = fill; k > pos; k--)
                begin
                    slot_stamp[k] = slot_stamp[k-1];
                    slot_proc[k]  = slot_proc[k-1];
                end
                slot_stamp[pos] = st;
                slot_proc[pos]  = pid;
                fill++;
            end
        end
        else if (fill != 0)
        begin
            res.popped = {1'b0, slot_proc[0]};
            for (k = 1; k < fill; k++)
            begin
                slot_stamp[k-1] = slot_stamp[k];
                slot_proc[k-1]  = slot_proc[k];
            end
            fill--;
        end
        res.head     = (fill != 0) ? {1'b0, slot_proc[0]} : NO_ID;
        res.is_empty = (fill == 0);
        return res;
    endfunction

    function automatic int field_differs(input string name,
                                         input logic signed [ID_W-1:0] exp,
                                         input logic signed [ID_W-1:0] got);
        if (got !== exp)
        begin
            $error("%s: expected %0d, got %0d", name, exp, got);
            return 1;
        end
        return 0;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill = 0;
            pending_outcomes.delete();
            outstanding <= 0;
            mismatches  <= 0;
        end
        else
        begin
            // result first: it always belongs to an earlier transfer
            if (out_valid && out_ready)
            begin
                if (pending_outcomes.size() == 0)
                begin
                    $error("result transfer with nothing pending: popped_id=%0d head_id=%0d",
                           popped_id, head_id);
                    bad_fields++;
                end
                else
                begin
                    want = pending_outcomes.pop_front();
                    bad_fields += field_differs("popped_id", want.popped, popped_id);
                    bad_fields += field_differs("head_id", want.head, head_id);
                    bad_fields += field_differs("empty_res", ID_W'(want.is_empty),
                                                ID_W'(empty_res));
                    bad_fields += field_differs("overflow", ID_W'(want.dropped),
                                                ID_W'(overflow));
                end
            end
            if (in_valid && in_ready)
                pending_outcomes.push_back(apply_request(action, proc_id, stamp));
            outstanding <= pending_outcomes.size();
            mismatches  <= bad_fields;
        end
    end

endmodule

### tb/sv/timestamp_ordered_request_queue_tb.sv
// ----------------------------------------------------------------------------
// Request queue testbench
// Directed fill/drain with tie and overflow cases, then random push/pop phases
// with skewed mixes and narrow key ranges, random gaps on both channels.
// ----------------------------------------------------------------------------
module timestamp_ordered_request_queue_tb;
    import tsoq_pkg::*;

    localparam int CAPACITY     = 16;
    localparam int RANDOM_ITEMS = 1200;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 in_valid  = 1'b0;
    logic                 action    = ACT_PUSH;
    logic [PROC_W-1:0]    proc_id   = '0;
    logic [STAMP_W-1:0]   stamp     = '0;
    logic                 out_ready = 1'b0;
    logic                 in_ready;
    logic                 out_valid;
    logic signed [ID_W-1:0] popped_id;
    logic signed [ID_W-1:0] head_id;
    logic                 empty_res;
    logic                 overflow;

    int   outstanding;
    int   mismatches;
    logic no_idle    = 1'b0;
    int   stall_left = 0;
    int   ready_roll;
    int   push_count  = 0;
    int   pop_count   = 0;
    int   phase_count = 0;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    timestamp_ordered_request_queue #(
        .CAPACITY (CAPACITY)
    ) DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .action    (action),
        .proc_id   (proc_id),
        .stamp     (stamp),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .popped_id (popped_id),
        .head_id   (head_id),
        .empty_res (empty_res),
        .overflow  (overflow)
    );

    timestamp_ordered_request_queue_checker #(
        .CAPACITY (CAPACITY)
    ) order_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .action      (action),
        .proc_id     (proc_id),
        .stamp       (stamp),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .popped_id   (popped_id),
        .head_id     (head_id),
        .empty_res   (empty_res),
        .overflow    (overflow),
        .outstanding (outstanding),
        .mismatches  (mismatches)
    );

    // result side back-pressure: mostly short stalls, now and then a long one
    always @(posedge clk)
    begin
        if (no_idle) begin
            out_ready <= 1'b1;
        end
        else if (stall_left != 0) begin
            out_ready  <= 1'b0;
            stall_left <= stall_left - 1;
        end
        else begin
            ready_roll = $urandom_range(0, 99);
            if (ready_roll < 65) begin
                out_ready <= 1'b1;
            end
            else if (ready_roll < 95) begin
                out_ready  <= 1'b0;
                stall_left <= $urandom_range(0, 2);
            end
            else begin
                out_ready  <= 1'b0;
                stall_left <= $urandom_range(10, 50);
            end
        end
    end

    // returns at the edge where the request transfer happens
    task automatic send_request(input logic act, input logic [PROC_W-1:0] pid,
                                input logic [STAMP_W-1:0] st);
        int gap;
        int roll;
        roll = $urandom_range(0, 99);
        if (no_idle || roll < 55)
            gap = 0;
        else if (roll < 93)
            gap = $urandom_range(1, 3);
        else
            gap = $urandom_range(8, 40);
        if (gap != 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        action   <= act;
        proc_id  <= pid;
        stamp    <= st;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        if (act == ACT_PUSH)
            push_count++;
        else
            pop_count++;
    endtask

    task automatic settle_queue();
        in_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0) @(posedge clk);
    endtask

    initial
    begin : stimulus
        int                 sent;
        int                 phase_len;
        int                 push_pct;
        int                 key_mode;
        logic               act;
        logic [PROC_W-1:0]  pid;
        logic [STAMP_W-1:0] st;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // pop on empty, key fields must be ignored
        send_request(ACT_POP, 7'd127, 15'h7FFF);
        // extremes, equal stamps ordered by id, identical keys kept in arrival order
        send_request(ACT_PUSH, 7'd127, 15'd32767);
        send_request(ACT_PUSH, 7'd0,   15'd0);
        send_request(ACT_PUSH, 7'd0,   15'd32767);
        send_request(ACT_PUSH, 7'd127, 15'd0);
        send_request(ACT_PUSH, 7'd64,  15'd16384);
        send_request(ACT_PUSH, 7'd64,  15'd16384);
        send_request(ACT_PUSH, 7'd63,  15'd16384);
        send_request(ACT_PUSH, 7'd65,  15'd16384);
        send_request(ACT_PUSH, 7'd10,  15'd16385);
        send_request(ACT_PUSH, 7'd10,  15'd16383);
        send_request(ACT_PUSH, 7'd1,   15'd1);
        send_request(ACT_PUSH, 7'd126, 15'd32766);
        send_request(ACT_PUSH, 7'd85,  15'd21845);
        send_request(ACT_PUSH, 7'd42,  15'd10922);
        send_request(ACT_PUSH, 7'd64,  15'd16384);
        send_request(ACT_PUSH, 7'd3,   15'd0);
        // queue is full now: the next two pushes get dropped
        send_request(ACT_PUSH, 7'd0,   15'd0);
        send_request(ACT_PUSH, 7'd127, 15'd32767);
        send_request(ACT_POP,  7'd0,   15'd0);
        send_request(ACT_POP,  7'd85,  15'd21845);
        settle_queue();

        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            phase_count++;
            phase_len = $urandom_range(30, 120);
            case ($urandom_range(0, 2))
                0:       push_pct = 80;
                1:       push_pct = 25;
                default: push_pct = 50;
            endcase
            key_mode = $urandom_range(0, 2);
            no_idle <= ($urandom_range(0, 4) == 0);
            repeat (phase_len)
            begin
                act = ($urandom_range(0, 99) < push_pct) ? ACT_PUSH : ACT_POP;
                case (key_mode)
                    // tiny key space: lots of ties and identical keys
                    1: begin
                        pid = PROC_W'($urandom_range(0, 3));
                        st  = STAMP_W'($urandom_range(0, 3));
                    end
                    2: begin
                        pid = PROC_W'($urandom_range(0, 127));
                        st  = STAMP_W'($urandom_range(32760, 32767));
                    end
                    default: begin
                        pid = PROC_W'($urandom_range(0, 127));
                        st  = STAMP_W'($urandom_range(0, 32767));
                    end
                endcase
                send_request(act, pid, st);
                sent++;
            end
            if ($urandom_range(0, 3) == 0)
                settle_queue();
        end

        settle_queue();
        repeat (8) @(posedge clk);
        $display("Covered %0d requests (%0d push, %0d pop) over %0d random phases,",
                 push_count + pop_count, push_count, pop_count, phase_count);
        $display("including a full queue with dropped pushes and pops on an empty queue.");
        if (mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("Run timed out with %0d results outstanding", outstanding);
        $display("FAILURE");
        $finish;
    end

endmodule
